// File: design/ordered_list_insert_read_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list core
// Shared property wrappers with clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_READ_CORE_MACROS_SVH
`define ORDERED_LIST_INSERT_READ_CORE_MACROS_SVH

// plain property under clock and reset
`define OLIR_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication in the same cycle
`define OLIR_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// implication into the next cycle
`define OLIR_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/olir_pkg.sv
// ----------------------------------------------------------------------------
// olir_pkg
// Types and constants of the ordered list core.
// ----------------------------------------------------------------------------
package olir_pkg;

  localparam int unsigned POS_W        = 6;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned DATA_W_DEF   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic             shift_en;
    logic [POS_W-1:0] position;
  } cell_ctrl_t;

endpackage

// File: design/olir_if.sv
// ----------------------------------------------------------------------------
// olir_if
// Valid/ready channels of the ordered list core: request and result beats.
// ----------------------------------------------------------------------------
interface olir_in_if;
  logic                               valid;
  logic                               ready;
  logic [olir_pkg::OP_W-1:0]          op;
  logic [olir_pkg::POS_W-1:0]         position;
  logic signed [olir_pkg::VALUE_W-1:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface olir_out_if;
  logic                                valid;
  logic                                ready;
  logic [olir_pkg::STATUS_W-1:0]       status;
  logic signed [olir_pkg::VALUE_W-1:0] read_data;
  logic [olir_pkg::COUNT_W-1:0]        count;
  logic                                empty_res;

  modport source (output valid, output status, output read_data, output count,
                  output empty_res, input ready);
  modport sink   (input valid, input status, input read_data, input count,
                  input empty_res, output ready);
endinterface

// File: design/olir_cell.sv
// ----------------------------------------------------------------------------
// olir_cell
// One list slot: holds a word, takes its lower neighbour's word on an insert
// below it, or the new value on an insert at its own place.
// ----------------------------------------------------------------------------
module olir_cell #(
  parameter int unsigned DATA_WIDTH = olir_pkg::DATA_W_DEF,
  parameter int unsigned CMP_W      = 7,
  parameter int unsigned INDEX      = 0
) (
  input  logic                   clk_i,
  input  olir_pkg::cell_ctrl_t   ctrl_i,
  input  logic [DATA_WIDTH-1:0]  value_i,
  input  logic [DATA_WIDTH-1:0]  prev_i,
  output logic [DATA_WIDTH-1:0]  data_o
);

  localparam logic [CMP_W-1:0] MyIdx = CMP_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [CMP_W-1:0]      pos_ext;

  assign pos_ext = CMP_W'(ctrl_i.position);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_en) begin
      if (MyIdx > pos_ext) begin
        data_d = prev_i;
      end else if (MyIdx == pos_ext) begin
        data_d = value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: design/ordered_list_insert_read_core.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_read_core
// Fixed-capacity ordered list of signed words held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries request beats (op, position, value): insert, read or clear.
//   out_o carries one result beat per request: status, read_data, count and
//   empty_res. Both channels use valid/ready.
//   A result beat appears in the cycle after its request is taken.
//   Throughput is one request per cycle while the receiver takes each
//   result; an insert moves every cell above the position up by one place
//   in the same cycle as the request is taken.
//   Reads pick the cell at the position through a one-hot select into the
//   registered result.
//   Reset clears the fill count and the result valid; cell contents are not
//   reset and a clear keeps them.
//   When the receiver stalls, the result beat holds and in_i.ready drops
//   until it is taken; a new request is taken in the cycle the result
//   leaves.
// ----------------------------------------------------------------------------
module ordered_list_insert_read_core #(
  parameter int unsigned CAPACITY   = olir_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = olir_pkg::DATA_W_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  olir_in_if.sink    in_i,
  olir_out_if.source out_o
);

  localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (FILL_W > olir_pkg::POS_W) ? FILL_W : olir_pkg::POS_W;
  localparam int unsigned VW     = olir_pkg::VALUE_W;

  logic [FILL_W-1:0]     fill_q, fill_d;
  logic                  out_valid_q;
  olir_pkg::status_e     status_q, status_d;
  logic [VW-1:0]         rdata_q, rdata_d;
  logic [olir_pkg::COUNT_W-1:0] count_q;
  logic                  empty_q;

  logic                  accept;
  logic                  ins;
  logic [CMP_W-1:0]      pos_ext, fill_ext;
  logic [DATA_WIDTH-1:0] store_val;
  logic [DATA_WIDTH-1:0] sel;
  logic [VW-1:0]         sel_wide;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  olir_pkg::cell_ctrl_t  ctrl;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign pos_ext    = CMP_W'(in_i.position);
  assign fill_ext   = CMP_W'(fill_q);

  generate
    if (DATA_WIDTH <= VW) begin : g_store_narrow
      assign store_val = in_i.value[DATA_WIDTH-1:0];
    end else begin : g_store_wide
      assign store_val = {{(DATA_WIDTH-VW){in_i.value[VW-1]}}, in_i.value};
    end
    if (DATA_WIDTH >= VW) begin : g_read_wide
      assign sel_wide = sel[VW-1:0];
    end else begin : g_read_narrow
      assign sel_wide = {{(VW-DATA_WIDTH){sel[DATA_WIDTH-1]}}, sel};
    end
  endgenerate

  assign ctrl.shift_en = accept && ins;
  assign ctrl.position = in_i.position;

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev;
      if (g == 0) begin : g_first
        assign prev = '0;
      end else begin : g_rest
        assign prev = cell_data[g-1];
      end
      olir_cell #(
        .DATA_WIDTH(DATA_WIDTH),
        .CMP_W     (CMP_W),
        .INDEX     (g)
      ) u_cell (
        .clk_i  (clk_i),
        .ctrl_i (ctrl),
        .value_i(store_val),
        .prev_i (prev),
        .data_o (cell_data[g])
      );
    end
  endgenerate

  always_comb begin
    sel = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (CMP_W'(k) == pos_ext) begin
        sel = sel | cell_data[k];
      end
    end
  end

  always_comb begin
    status_d = olir_pkg::ST_OK;
    rdata_d  = '0;
    fill_d   = fill_q;
    ins      = 1'b0;
    case (olir_pkg::op_e'(in_i.op))
      olir_pkg::OP_INSERT: begin
        if (pos_ext > fill_ext) begin
          status_d = olir_pkg::ST_RANGE;
        end else if (fill_q == FILL_W'(CAPACITY)) begin
          status_d = olir_pkg::ST_FULL;
        end else begin
          ins    = 1'b1;
          fill_d = fill_q + FILL_W'(1);
        end
      end
      olir_pkg::OP_READ: begin
        if (pos_ext >= fill_ext) begin
          status_d = olir_pkg::ST_RANGE;
        end else begin
          rdata_d = sel_wide;
        end
      end
      olir_pkg::OP_CLEAR: begin
        fill_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rdata_q  <= rdata_d;
      count_q  <= olir_pkg::COUNT_W'(fill_d);
      empty_q  <= (fill_d == '0);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = status_q;
  assign out_o.read_data = rdata_q;
  assign out_o.count     = count_q;
  assign out_o.empty_res = empty_q;

endmodule

// File: design/olir_checker.sv
// ----------------------------------------------------------------------------
// olir_checker
// Port-level checks of the ordered list core, bound to the top level.
// ----------------------------------------------------------------------------
`include "ordered_list_insert_read_core_macros.svh"

module olir_checker #(
  parameter int unsigned CAPACITY = olir_pkg::CAPACITY_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [olir_pkg::STATUS_W-1:0]  status_i,
  input logic [olir_pkg::VALUE_W-1:0]   read_data_i,
  input logic [olir_pkg::COUNT_W-1:0]   count_i,
  input logic                           empty_res_i
);

  `OLIR_ASSERT_IMP(a_empty_flag, clk_i, rst_ni, out_valid_i,
    empty_res_i == (count_i == '0), "empty flag disagrees with count")
  `OLIR_ASSERT_IMP(a_full_count, clk_i, rst_ni, out_valid_i && status_i == olir_pkg::ST_FULL,
    count_i == olir_pkg::COUNT_W'(CAPACITY), "full status with list not full")
  `OLIR_ASSERT_IMP(a_data_ok, clk_i, rst_ni, out_valid_i && read_data_i != '0,
    status_i == olir_pkg::ST_OK, "read data on a failed beat")
  `OLIR_ASSERT(a_ready_free, clk_i, rst_ni, out_valid_i || in_ready_i,
    "request stalled with no result pending")
  `OLIR_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(count_i), "stalled result beat changed")

endmodule

bind ordered_list_insert_read_core olir_checker #(
  .CAPACITY(CAPACITY)
) u_olir_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .status_i   (out_o.status),
  .read_data_i(out_o.read_data),
  .count_i    (out_o.count),
  .empty_res_i(out_o.empty_res)
);
